// File: rtl/fsa_pkg.sv
// Shared types and constants for the fixed-size slot allocator.
// No dependencies; compile first.
package fsa_pkg;

  localparam int SLOT_W     = 10;
  localparam int PSIZE_W    = 13;
  localparam int OFFSET_W   = 22;
  localparam int COUNT_W    = 11;
  localparam int MAX_PIECES = 1024;

  localparam logic               CMD_RETAIN  = 1'b0;
  localparam logic               CMD_RELEASE = 1'b1;
  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 13'd8;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fsa_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } fsa_cmd_t;

endpackage

// File: rtl/fsa_in_if.sv
// Request channel: valid/ready handshake carrying cmd and slot.
// Depends on fsa_pkg.
interface fsa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [fsa_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output cmd, output slot, input ready);
  modport sink   (input valid, input cmd, input slot, output ready);
endinterface

// File: rtl/fsa_out_if.sv
// Result channel: valid/ready handshake carrying ok, slot, offset and count.
// Depends on fsa_pkg.
interface fsa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [fsa_pkg::SLOT_W-1:0]   slot_out;
  logic [fsa_pkg::OFFSET_W-1:0] byte_offset;
  logic [fsa_pkg::COUNT_W-1:0]  in_use;

  modport source (output valid, output ok, output slot_out, output byte_offset,
                  output in_use, input ready);
  modport sink   (input valid, input ok, input slot_out, input byte_offset,
                  input in_use, output ready);
endinterface

// File: rtl/fixed_size_slot_allocator.sv
// A request beat is captured in ST_IDLE and executes in ST_EXEC once the result
// register is free; its result beat is registered. No new request is taken until
// the last one executes, set by the registered read of the link memory at the free head.
// Reset: synchronous; free head empty, bump pointer and count zero, piece size 8.
// The link memory is not cleared; no clearing pass is needed.
module fixed_size_slot_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  fsa_in_if.sink                       in_ch,
  fsa_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [fsa_pkg::PSIZE_W-1:0]  cfg_wdata
);
  import fsa_pkg::*;

  fsa_cmd_t cmd;

  fsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_cmd    (in_ch.cmd),
    .req_slot   (in_ch.slot),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_ok     (out_ch.ok),
    .res_slot   (out_ch.slot_out),
    .res_offset (out_ch.byte_offset),
    .res_in_use (out_ch.in_use)
  );

endmodule

// File: rtl/fsa_ctrl.sv
// Controller: request/result handshake and the two-state sequencer.
// Depends on fsa_pkg.
module fsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fsa_pkg::fsa_cmd_t cmd
);
  import fsa_pkg::*;

  fsa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result beat slot is free
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_exec_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r && state_r == ST_IDLE)
    else $error("execute did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

endmodule

// File: rtl/fsa_dp.sv
// Datapath: free-list head, bump pointer, in-use count, link memory,
// piece size register and the registered result. Depends on fsa_pkg.
module fsa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsa_pkg::fsa_cmd_t             cmd,
  input  logic                          req_cmd,
  input  logic [fsa_pkg::SLOT_W-1:0]    req_slot,
  input  logic                          cfg_we,
  input  logic [fsa_pkg::PSIZE_W-1:0]   cfg_wdata,
  output logic                          res_ok,
  output logic [fsa_pkg::SLOT_W-1:0]    res_slot,
  output logic [fsa_pkg::OFFSET_W-1:0]  res_offset,
  output logic [fsa_pkg::COUNT_W-1:0]   res_in_use
);
  import fsa_pkg::*;

  localparam int PW = $clog2(MAX_PIECES + 1);
  localparam int IW = $clog2(MAX_PIECES);
  localparam int XW = (PW > COUNT_W) ? PW : COUNT_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(MAX_PIECES);

  logic [PW-1:0]      link_mem [MAX_PIECES];
  logic [PW-1:0]      link_rd_r;
  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      bump_r, bump_nxt;
  logic [PW-1:0]      count_r, count_nxt;
  logic [PSIZE_W-1:0] psize_r;
  logic               cmd_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [XW-1:0]      slot_x;
  logic [XW-1:0]      got;
  logic [XW-1:0]      count_x;
  logic [XW+PSIZE_W-1:0] prod;
  logic               ok_nxt;
  logic               mem_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NULL_PTR;
      bump_r  <= '0;
      count_r <= '0;
      psize_r <= PSIZE_RESET;
    end else begin
      if (cmd.exec) begin
        head_r  <= head_nxt;
        bump_r  <= bump_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        psize_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= req_cmd;
      slot_r    <= req_slot;
      link_rd_r <= link_mem[head_r[IW-1:0]];
    end
    if (cmd.exec && mem_we) begin
      link_mem[slot_x[IW-1:0]] <= head_r;
    end
  end

  assign slot_x = XW'(slot_r);

  always_comb begin
    head_nxt  = head_r;
    bump_nxt  = bump_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    got       = '0;
    mem_we    = 1'b0;
    if (cmd_r == CMD_RETAIN) begin
      if (count_r >= NULL_PTR) begin
        ok_nxt = 1'b0;
      end else if (head_r < NULL_PTR) begin
        got       = XW'(head_r);
        head_nxt  = (link_rd_r > NULL_PTR) ? NULL_PTR : link_rd_r;
        count_nxt = count_r + 1'b1;
        ok_nxt    = 1'b1;
      end else if (bump_r < NULL_PTR) begin
        got       = XW'(bump_r);
        bump_nxt  = bump_r + 1'b1;
        count_nxt = count_r + 1'b1;
        ok_nxt    = 1'b1;
      end
    end else begin
      got = slot_x;
      if (!(slot_x >= XW'(bump_r) || slot_x >= XW'(NULL_PTR) || count_r == '0)) begin
        mem_we    = 1'b1;
        head_nxt  = slot_x[PW-1:0];
        count_nxt = count_r - 1'b1;
        ok_nxt    = 1'b1;
      end
    end
  end

  assign prod    = got * psize_r;
  assign count_x = XW'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ok     <= ok_nxt;
      res_slot   <= got[SLOT_W-1:0];
      res_offset <= prod[OFFSET_W-1:0];
      res_in_use <= count_x[COUNT_W-1:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NULL_PTR && bump_r <= NULL_PTR)
    else $error("in-use count or bump pointer out of range");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NULL_PTR)
    else $error("free head out of range");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && mem_we |=> head_r == $past(slot_x[PW-1:0]))
    else $error("released slot not at free head");

endmodule

// File: verif/fixed_size_slot_allocator_tb.sv
// Testbench for fixed_size_slot_allocator: retain/release beats checked against an
// in-bench slab predictor, under random idling and several piece sizes.
// Depends on fsa_pkg, fsa_in_if, fsa_out_if and the allocator RTL.
`timescale 1ns / 1ps

module fixed_size_slot_allocator_tb;
  import fsa_pkg::*;

  localparam int POOL_SLOTS = MAX_PIECES;
  localparam int POOL_CHECK = 0;
  localparam int POOL_PLAN  = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 200;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot_out;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  in_use;
  } grant_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PSIZE_W-1:0] cfg_wdata;

  fsa_in_if  in_ch();
  fsa_out_if out_ch();

  fixed_size_slot_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [COUNT_W-1:0] link_mem [2][POOL_SLOTS];
  logic [COUNT_W-1:0] free_head [2];
  logic [COUNT_W-1:0] bump_ptr [2];
  logic [COUNT_W-1:0] used_cnt [2];
  logic [PSIZE_W-1:0] piece_bytes [2];

  req_t              req_q[$];
  grant_t            grant_q[$];
  logic [SLOT_W-1:0] held_q[$];
  logic [SLOT_W-1:0] last_freed;

  logic req_fire;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   errors;
  int   cycles;

  function automatic grant_t slab_step(input int pid, input logic cmd,
                                       input logic [SLOT_W-1:0] s);
    grant_t                     g;
    logic                       ok;
    logic [COUNT_W-1:0]         got;
    logic [SLOT_W+PSIZE_W-1:0]  prod;
    ok  = 1'b0;
    got = '0;
    if (cmd == CMD_RETAIN) begin
      if (used_cnt[pid] < POOL_SLOTS) begin
        if (free_head[pid] < POOL_SLOTS) begin
          got = free_head[pid];
          free_head[pid] = link_mem[pid][got[SLOT_W-1:0]];
          if (free_head[pid] > POOL_SLOTS) free_head[pid] = POOL_SLOTS;
          ok = 1'b1;
        end else if (bump_ptr[pid] < POOL_SLOTS) begin
          got = bump_ptr[pid];
          bump_ptr[pid] = bump_ptr[pid] + 1'b1;
          ok = 1'b1;
        end
      end
      if (ok) used_cnt[pid] = used_cnt[pid] + 1'b1;
    end else begin
      got = {1'b0, s};
      if (s < bump_ptr[pid] && used_cnt[pid] != 0) begin
        link_mem[pid][s] = free_head[pid];
        free_head[pid]   = {1'b0, s};
        used_cnt[pid]    = used_cnt[pid] - 1'b1;
        ok = 1'b1;
      end
    end
    prod          = got[SLOT_W-1:0] * piece_bytes[pid];
    g.ok          = ok;
    g.slot_out    = got[SLOT_W-1:0];
    g.byte_offset = prod[OFFSET_W-1:0];
    g.in_use      = used_cnt[pid];
    return g;
  endfunction

  task automatic queue_req(input logic cmd, input logic [SLOT_W-1:0] s);
    req_t   r;
    grant_t g;
    r.cmd  = cmd;
    r.slot = s;
    req_q.push_back(r);
    g = slab_step(POOL_PLAN, cmd, s);
    if (g.ok) begin
      if (cmd == CMD_RETAIN) begin
        held_q.push_back(g.slot_out);
      end else begin
        last_freed = s;
        for (int k = 0; k < held_q.size(); k++) begin
          if (held_q[k] == s) begin
            held_q.delete(k);
            break;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input int n, input int retain_pct);
    int idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < retain_pct) begin
        queue_req(CMD_RETAIN, SLOT_W'($urandom_range(POOL_SLOTS - 1)));
      end else if (held_q.size() != 0 && $urandom_range(99) < 85) begin
        idx = $urandom_range(held_q.size() - 1);
        queue_req(CMD_RELEASE, held_q[idx]);
      end else if ($urandom_range(1) == 0) begin
        queue_req(CMD_RELEASE, last_freed);
      end else begin
        queue_req(CMD_RELEASE, SLOT_W'($urandom_range(POOL_SLOTS - 1)));
      end
    end
  endtask

  task automatic wait_settled();
    do @(posedge clk);
    while (req_q.size() != 0 || in_ch.valid || grant_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_piece_size(input logic [PSIZE_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    piece_bytes[POOL_CHECK] = v;
    piece_bytes[POOL_PLAN]  = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** fixed_size_slot_allocator: FAILED **");
      $finish;
    end
  end

  // drive request beats and result-side backpressure
  always @(negedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || req_fire) begin
        if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = req_q.pop_front();
          in_ch.cmd   <= nxt.cmd;
          in_ch.slot  <= nxt.slot;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    grant_t want;
    req_fire <= rst_n && in_ch.valid && (in_ch.ready === 1'b1);
    if (rst_n && in_ch.valid && in_ch.ready === 1'b1)
      grant_q.push_back(slab_step(POOL_CHECK, in_ch.cmd, in_ch.slot));
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (grant_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < REPORT_MAX)
          $display("%0t: unexpected beat: expected none, %s%0d slot=%0d offset=%0d in_use=%0d",
                   $time, "got ok=", out_ch.ok, out_ch.slot_out, out_ch.byte_offset,
                   out_ch.in_use);
      end else begin
        want = grant_q.pop_front();
        if (out_ch.ok !== want.ok || out_ch.slot_out !== want.slot_out ||
            out_ch.byte_offset !== want.byte_offset || out_ch.in_use !== want.in_use) begin
          errors <= errors + 1;
          if (errors < REPORT_MAX)
            $display({"%0t: mismatch: expected ok=%0d slot=%0d offset=%0d in_use=%0d,",
                      " got ok=%0d slot=%0d offset=%0d in_use=%0d"},
                     $time, want.ok, want.slot_out, want.byte_offset, want.in_use,
                     out_ch.ok, out_ch.slot_out, out_ch.byte_offset, out_ch.in_use);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = PSIZE_RESET;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_RETAIN;
    in_ch.slot   = '0;
    out_ch.ready = 1'b0;
    req_fire     = 1'b0;
    errors       = 0;
    cycles       = 0;
    last_freed   = '0;
    for (int p = 0; p < 2; p++) begin
      free_head[p]   = POOL_SLOTS;
      bump_ptr[p]    = '0;
      used_cnt[p]    = '0;
      piece_bytes[p] = PSIZE_RESET;
      for (int k = 0; k < POOL_SLOTS; k++) link_mem[p][k] = '0;
    end
    src_idle_pct = 16;
    snk_idle_pct = 68;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // nothing handed out yet, then bump allocation, LIFO reuse, double release
    queue_req(CMD_RELEASE, 10'd0);
    queue_req(CMD_RELEASE, 10'd1023);
    queue_req(CMD_RETAIN,  10'd1023);
    queue_req(CMD_RETAIN,  10'd0);
    queue_req(CMD_RETAIN,  10'd512);
    queue_req(CMD_RELEASE, 10'd5);
    queue_req(CMD_RELEASE, 10'd1);
    queue_req(CMD_RELEASE, 10'd0);
    queue_req(CMD_RETAIN,  10'd341);
    queue_req(CMD_RETAIN,  10'd682);
    queue_req(CMD_RELEASE, 10'd2);
    queue_req(CMD_RELEASE, 10'd2);
    queue_req(CMD_RETAIN,  10'd0);
    queue_req(CMD_RETAIN,  10'd1023);
    queue_req(CMD_RELEASE, 10'd0);
    queue_req(CMD_RELEASE, 10'd1);
    queue_req(CMD_RELEASE, 10'd2);
    queue_req(CMD_RELEASE, 10'd2);
    wait_settled();

    write_piece_size(13'd4096);
    run_phase(300, 75);
    wait_settled();

    src_idle_pct = 68;
    snk_idle_pct = 16;
    write_piece_size(13'h1FFF);
    run_phase(450, 97);
    wait_settled();

    write_piece_size(13'd8);
    run_phase(450, 97);
    wait_settled();

    // fill to exhaustion, then drain deep into the free list
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_piece_size(PSIZE_W'($urandom_range(4096, 8)));
    run_phase(250, 85);
    wait_settled();

    write_piece_size(13'd0);
    run_phase(200, 30);
    wait_settled();

    repeat (4) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("** fixed_size_slot_allocator: PASSED **");
    end else begin
      $display("** fixed_size_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule
